>>> rtl/bsal_pkg.sv
// Shared types and codes for the bounded sorted array list.
// No dependencies; imported by every module of the block.
package bsal_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned PAY_W   = 64;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CNT_O_W = 7;

  // Command codes as they arrive on the input.
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT  = 3'd0,
    CMD_INS_SORTED = 3'd1,
    CMD_APPEND     = 3'd2,
    CMD_REM_FRONT  = 3'd3,
    CMD_REM_KEY    = 3'd4,
    CMD_REM_LAST   = 3'd5,
    CMD_SEARCH     = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_SEARCH
  } op_e;

  // Where the operation lands: front, by key match / order, or tail.
  typedef enum logic [1:0] {
    AT_FRONT,
    AT_KEY,
    AT_BACK
  } where_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INS,
    ST_REM
  } state_e;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } rec_t;

  typedef struct packed {
    op_e    op;
    where_e where;
    rec_t   rec;
  } cmd_t;

  typedef struct packed {
    logic               ok;
    rec_t               found;
    logic [CNT_O_W-1:0] entry_count;
    logic               is_full;
    logic               is_empty;
  } res_t;

endpackage

>>> rtl/bounded_sorted_array_list.sv
// Bounded sorted array list, top level.
// Depends on bsal_pkg, bsal_front, bsal_engine and bsal_res_q.
//
// A list of up to CAPACITY keyed records kept contiguously in one memory
// (one write and one registered read per cycle). Each request is one
// command: insert at front, insert in signed ascending key order (before the
// first record whose key is not smaller, so a new record goes ahead of equal
// keys), append, remove front, remove first match, remove last, or search
// for the first match. Every request gives exactly one result with ok, the
// found record (zero unless a search hits), the count after the request and
// full/empty flags. Requests enter a two-slot queue and results leave through
// another, so the engine runs one request at a time while both sides move
// freely. The engine answers a rejected request (insert when full, remove when
// empty, unused code) as soon as it takes it. Append and remove-last touch
// only the tail; remove front and insert front shift every record; sorted
// insert, remove by key and search scan from the front to the first hit, and
// sorted insert and remove by key then shift the records behind it. The worst
// case (sorted insert with CAPACITY-1 records, remove by key or search miss
// on a full list) is set by the memory read port: the scan and the shift each
// touch one record per cycle, and the shift follows the scan in the same pass.
module bounded_sorted_array_list #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [bsal_pkg::CMD_W-1:0]          cmd_i,
  input  logic signed [bsal_pkg::KEY_W-1:0]   key_i,
  input  logic [bsal_pkg::PAY_W-1:0]          record_payload_i,
  output logic                                empty,
  input  logic                                pop,
  output logic                                ok_o,
  output logic signed [bsal_pkg::KEY_W-1:0]   found_key_o,
  output logic [bsal_pkg::PAY_W-1:0]          found_payload_o,
  output logic [bsal_pkg::CNT_O_W-1:0]        entry_count_o,
  output logic                                is_full_o,
  output logic                                is_empty_o
);
  import bsal_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  logic res_valid, res_space;
  res_t res, head;

  // decode and buffer incoming requests
  bsal_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .cmd_i            (cmd_i),
    .key_i            (key_i),
    .record_payload_i (record_payload_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  // engine only starts a request when the result queue has a free slot
  bsal_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_ready_i (res_space),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bsal_res_q u_res_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (res_space),
    .empty       (empty),
    .pop         (pop),
    .head_o      (head)
  );

  assign ok_o            = head.ok;
  assign found_key_o     = head.found.key;
  assign found_payload_o = head.found.payload;
  assign entry_count_o   = head.entry_count;
  assign is_full_o       = head.is_full;
  assign is_empty_o      = head.is_empty;

endmodule

>>> rtl/bsal_front.sv
// Front end: decodes incoming requests and buffers them in a two-slot queue.
// Depends on bsal_pkg.
module bsal_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [bsal_pkg::CMD_W-1:0]        cmd_i,
  input  logic signed [bsal_pkg::KEY_W-1:0] key_i,
  input  logic [bsal_pkg::PAY_W-1:0]        record_payload_i,
  output logic                              cmd_valid_o,
  output bsal_pkg::cmd_t                    cmd_o,
  input  logic                              cmd_pop_i
);
  import bsal_pkg::*;

  cmd_t       dec;
  cmd_t       slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_wr, do_rd;

  always_comb begin
    dec.rec.key     = key_i;
    dec.rec.payload = record_payload_i;
    dec.op          = OP_NONE;
    dec.where       = AT_FRONT;
    case (cmd_i)
      CMD_INS_FRONT: begin
        dec.op = OP_INSERT;
        dec.where = AT_FRONT;
      end
      CMD_INS_SORTED: begin
        dec.op = OP_INSERT;
        dec.where = AT_KEY;
      end
      CMD_APPEND: begin
        dec.op = OP_INSERT;
        dec.where = AT_BACK;
      end
      CMD_REM_FRONT: begin
        dec.op = OP_REMOVE;
        dec.where = AT_FRONT;
      end
      CMD_REM_KEY: begin
        dec.op = OP_REMOVE;
        dec.where = AT_KEY;
      end
      CMD_REM_LAST: begin
        dec.op = OP_REMOVE;
        dec.where = AT_BACK;
      end
      CMD_SEARCH: begin
        dec.op = OP_SEARCH;
        dec.where = AT_KEY;
      end
      default: begin
        dec.op = OP_NONE;
        dec.where = AT_FRONT;
      end
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_q];
  assign do_wr       = push && !full;
  assign do_rd       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_d  = do_wr ? ~wr_q : wr_q;
    rd_d  = do_rd ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_q] <= dec;
    end
  end

endmodule

>>> rtl/bsal_engine.sv
// Back end: record memory, count and the scan / shift sequencer.
// Depends on bsal_pkg.
module bsal_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  bsal_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_ready_i,
  output logic           res_valid_o,
  output bsal_pkg::res_t res_o
);
  import bsal_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   iss_q, iss_d;
  logic [CW-1:0]   chk_q, chk_d;
  logic            chk_vld_q, chk_vld_d;
  logic [CW-1:0]   wi_q, wi_d;
  rec_t            held_q, held_d;
  cmd_t            cur_q, cur_d;

  rec_t            mem [CAPACITY];
  rec_t            rd_data_q;
  logic [AW-1:0]   rd_addr;
  logic            we;
  logic [AW-1:0]   wa;
  rec_t            wd;

  logic            start, reject, needs_scan;
  logic            hit, scan_hit, scan_miss;
  logic            is_cap, is_zero;
  logic            ins_last, rem_last;
  logic            fin_ok;
  rec_t            fin_found;

  assign is_cap     = (count_q == CW'(CAPACITY));
  assign is_zero    = (count_q == '0);
  assign start      = (state_q == ST_IDLE) && cmd_valid_i && res_ready_i;
  assign reject     = (cmd_i.op == OP_NONE) ||
                      ((cmd_i.op == OP_INSERT) && is_cap) ||
                      ((cmd_i.op == OP_REMOVE) && is_zero);
  assign needs_scan = (cmd_i.where == AT_KEY) || (cmd_i.op == OP_SEARCH);

  // Sorted insert stops at the first key not smaller; others need equality.
  assign hit       = (cur_q.op == OP_INSERT) ?
                     ($signed(rd_data_q.key) >= $signed(cur_q.rec.key)) :
                     (rd_data_q.key == cur_q.rec.key);
  assign scan_hit  = chk_vld_q && hit;
  assign scan_miss = !chk_vld_q;
  assign ins_last  = (wi_q == count_q);
  assign rem_last  = (({1'b0, wi_q} + (CW + 1)'(1)) == {1'b0, count_q});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start && !reject) begin
          if (needs_scan) begin
            state_d = ST_SCAN;
          end else if (cmd_i.op == OP_INSERT) begin
            state_d = ST_INS;
          end else begin
            state_d = ST_REM;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_miss) begin
          if (cur_q.op == OP_INSERT) begin
            state_d = ST_INS;
          end else if ((cur_q.op == OP_REMOVE) && scan_hit) begin
            state_d = ST_REM;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_INS: begin
        if (ins_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_REM: begin
        if (rem_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d     = count_q;
    iss_d       = iss_q;
    chk_d       = chk_q;
    chk_vld_d   = 1'b0;
    wi_d        = wi_q;
    held_d      = held_q;
    cur_d       = cur_q;
    rd_addr     = '0;
    we          = 1'b0;
    wa          = AW'(wi_q);
    wd          = held_q;
    cmd_pop_o   = 1'b0;
    res_valid_o = 1'b0;
    fin_ok      = 1'b0;
    fin_found   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          held_d    = cmd_i.rec;
          if (reject) begin
            res_valid_o = 1'b1;
          end else if (needs_scan) begin
            rd_addr   = '0;
            chk_d     = '0;
            chk_vld_d = !is_zero;
            iss_d     = CW'(1);
          end else if (cmd_i.op == OP_INSERT) begin
            rd_addr = '0;
            wi_d    = (cmd_i.where == AT_BACK) ? count_q : '0;
          end else begin
            rd_addr = AW'(1);
            wi_d    = (cmd_i.where == AT_BACK) ? (count_q - CW'(1)) : '0;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          if (cur_q.op == OP_SEARCH) begin
            res_valid_o = 1'b1;
            fin_ok      = 1'b1;
            fin_found   = rd_data_q;
          end else if (cur_q.op == OP_REMOVE) begin
            rd_addr = AW'({1'b0, chk_q} + (CW + 1)'(1));
            wi_d    = chk_q;
          end else begin
            rd_addr = AW'(chk_q);
            wi_d    = chk_q;
          end
        end else if (scan_miss) begin
          if (cur_q.op == OP_INSERT) begin
            wi_d = count_q;
          end else begin
            res_valid_o = 1'b1;
          end
        end else begin
          // keep one read in flight ahead of the compare
          rd_addr   = AW'(iss_q);
          chk_d     = iss_q;
          chk_vld_d = (iss_q < count_q);
          if (iss_q < count_q) begin
            iss_d = iss_q + CW'(1);
          end
        end
      end
      ST_INS: begin
        // ripple: write the held record, pick up the one it displaces
        we = 1'b1;
        wa = AW'(wi_q);
        wd = held_q;
        if (ins_last) begin
          count_d     = count_q + CW'(1);
          res_valid_o = 1'b1;
          fin_ok      = 1'b1;
        end else begin
          held_d  = rd_data_q;
          rd_addr = AW'({1'b0, wi_q} + (CW + 1)'(1));
          wi_d    = wi_q + CW'(1);
        end
      end
      ST_REM: begin
        if (rem_last) begin
          count_d     = count_q - CW'(1);
          res_valid_o = 1'b1;
          fin_ok      = 1'b1;
        end else begin
          we      = 1'b1;
          wa      = AW'(wi_q);
          wd      = rd_data_q;
          rd_addr = AW'({1'b0, wi_q} + (CW + 1)'(2));
          wi_d    = wi_q + CW'(1);
        end
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_o.ok          = fin_ok;
    res_o.found       = fin_found;
    res_o.entry_count = CNT_O_W'(count_d);
    res_o.is_full     = (count_d == CW'(CAPACITY));
    res_o.is_empty    = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_q  <= iss_d;
    chk_q  <= chk_d;
    wi_q   <= wi_d;
    held_q <= held_d;
    cur_q  <= cur_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[rd_addr];
  end

endmodule

>>> rtl/bsal_res_q.sv
// Result queue: two-slot buffer between the engine and the result port.
// Depends on bsal_pkg.
module bsal_res_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  input  bsal_pkg::res_t res_i,
  output logic           space_o,
  output logic           empty,
  input  logic           pop,
  output bsal_pkg::res_t head_o
);
  import bsal_pkg::*;

  res_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_wr, do_rd;

  assign space_o = (cnt_q != 2'd2);
  assign empty   = (cnt_q == 2'd0);
  assign head_o  = slot_q[rd_q];
  assign do_wr   = res_valid_i && space_o;
  assign do_rd   = pop && !empty;
  assign cnt_d   = cnt_q + {1'b0, do_wr} - {1'b0, do_rd};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= do_wr ? ~wr_q : wr_q;
      rd_q  <= do_rd ? ~rd_q : rd_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_q] <= res_i;
    end
  end

endmodule
